// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked property, disabled while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/salwc_pkg.sv =====
// Package: geometry, payload and tag-row types for the LRU write-back cache tag store.
package salwc_pkg;

  localparam int NUM_SETS    = 256;
  localparam int NUM_WAYS    = 4;
  localparam int OFFSET_BITS = 6;
  localparam int ADDR_BITS   = 32;

  localparam int IDX_W = $clog2(NUM_SETS + 1) - 1;  // floor(log2(NUM_SETS))
  localparam int TAG_W = ADDR_BITS - OFFSET_BITS - IDX_W;
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e_t;

  typedef struct packed {
    logic [31:0] address;
    logic        command;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic       writeback;
    logic [1:0] way_used;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
    logic [WAY_W-1:0] rank;  // NUM_WAYS-1 = most recent, 0 = least recent
  } entry_t;

  typedef entry_t [NUM_WAYS-1:0] row_t;

  // Scan results handed from the compare unit to the update logic
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             inv_found;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] lru_way;
  } scan_t;

  // Row contents of a set that has never been written
  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      r[w].valid = 1'b0;
      r[w].dirty = 1'b0;
      r[w].tag   = '0;
      r[w].rank  = WAY_W'(w);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/salwc_way_scan.sv =====
// Shared compare unit: checks one way per cycle while step is high and accumulates hit, free and LRU way.
module salwc_way_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      step,
  input  logic [salwc_pkg::WAY_W-1:0] way_idx,
  input  salwc_pkg::entry_t         entry,
  input  logic [salwc_pkg::TAG_W-1:0] tag,
  output salwc_pkg::scan_t          result
);

  salwc_pkg::scan_t scan_r, scan_nxt;
  logic             match;

  assign match = entry.valid && (entry.tag == tag);

  always_comb begin
    scan_nxt = scan_r;
    if (start) begin
      scan_nxt.hit       = 1'b0;
      scan_nxt.inv_found = 1'b0;
    end else if (step) begin
      // lowest matching way wins
      if (!scan_r.hit && match) begin
        scan_nxt.hit     = 1'b1;
        scan_nxt.hit_way = way_idx;
      end
      if (!scan_r.inv_found && !entry.valid) begin
        scan_nxt.inv_found = 1'b1;
        scan_nxt.inv_way   = way_idx;
      end
      // ranks form a permutation: exactly one way holds rank 0
      if (entry.rank == '0) begin
        scan_nxt.lru_way = way_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign result = scan_r;

endmodule

// ===== rtl/core/set_assoc_lru_writeback_cache_unit.sv =====
// Top level: tag store of a 4-way set-associative write-back cache with true LRU.
// Usage:
//   in channel  (in_valid/in_ready/in_data): one beat per access, address and
//   command (read or write). out channel (out_valid/out_ready/out_data): one
//   beat per access with hit, writeback and the way that hit or was filled.
// Timing:
//   An access is taken in the idle cycle, its set row is read from the tag RAM,
//   then the shared compare unit checks one way per cycle, across every way of the set,
//   then the updated row is written back and the result is registered.
//   A new access is taken only in the idle state, after the update step, so
//   accesses do not overlap; the way-serial compare unit and the single-port
//   row RAM finish one access before the next is accepted.
// Reset:
//   Per-set init flags clear at once; a set never written reads as all ways
//   invalid, clean, with rank equal to way number. No clearing pass.
// Stall:
//   The result sits in an output register. If the receiver stalls, the block
//   holds in its update step until the register drains; no beat is lost.
`include "assert_macros.svh"

module set_assoc_lru_writeback_cache_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  salwc_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output salwc_pkg::out_t  out_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  localparam int LO = salwc_pkg::OFFSET_BITS;
  localparam int HI = salwc_pkg::OFFSET_BITS + salwc_pkg::IDX_W;

  state_t state_r, state_nxt;

  // tag RAM: one row (all ways of a set) per entry
  salwc_pkg::row_t tag_mem [salwc_pkg::NUM_SETS];
  salwc_pkg::row_t mem_q_r;
  logic [salwc_pkg::NUM_SETS-1:0] set_init_r;

  logic [salwc_pkg::IDX_W-1:0] set_r;
  logic [salwc_pkg::TAG_W-1:0] tag_r;
  logic                        cmd_r;
  salwc_pkg::row_t             row_r, row_nxt;
  logic [salwc_pkg::WAY_W-1:0] way_cnt_r, way_cnt_nxt;

  salwc_pkg::out_t out_r, out_nxt;
  logic            out_valid_r;

  logic                        in_accept;
  logic                        last_way;
  logic                        out_free;
  logic                        mem_we;
  logic [salwc_pkg::IDX_W-1:0] in_set;
  salwc_pkg::scan_t            scan;
  logic [salwc_pkg::WAY_W-1:0] vic;
  logic [salwc_pkg::WAY_W-1:0] old_rank;
  logic                        wb;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign in_set    = in_data.address[HI-1:LO];
  assign last_way  = (way_cnt_r == salwc_pkg::WAY_W'(salwc_pkg::NUM_WAYS - 1));
  assign out_free  = !out_valid_r || out_ready;
  assign mem_we    = (state_r == ST_UPD) && out_free;

  // ---- sequencer ----
  always_comb begin
    state_nxt   = state_r;
    way_cnt_nxt = way_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt   = ST_SCAN;
        way_cnt_nxt = '0;
      end
      ST_SCAN: begin
        way_cnt_nxt = way_cnt_r + 1'b1;
        if (last_way) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      way_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      way_cnt_r <= way_cnt_nxt;
    end
  end

  // ---- access capture ----
  always_ff @(posedge clk) begin
    if (in_accept) begin
      set_r <= in_set;
      tag_r <= in_data.address[salwc_pkg::ADDR_BITS-1:HI];
      cmd_r <= in_data.command;
    end
  end

  // ---- tag RAM: registered read on accept, write at end of update ----
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[set_r] <= row_nxt;
    end
    if (in_accept) begin
      mem_q_r <= tag_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_init_r <= '0;
    end else if (mem_we) begin
      set_init_r[set_r] <= 1'b1;
    end
  end

  // unwritten sets take their reset contents
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      row_r <= set_init_r[set_r] ? mem_q_r : salwc_pkg::reset_row();
    end
  end

  // ---- way-serial compare ----
  salwc_way_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_LOAD),
    .step    (state_r == ST_SCAN),
    .way_idx (way_cnt_r),
    .entry   (row_r[way_cnt_r]),
    .tag     (tag_r),
    .result  (scan)
  );

  // ---- row update: pick way, promote to MRU, set dirty, and valid/tag on a miss ----
  always_comb begin
    if (scan.hit) begin
      vic = scan.hit_way;
    end else if (scan.inv_found) begin
      vic = scan.inv_way;
    end else begin
      vic = scan.lru_way;
    end
    old_rank = row_r[vic].rank;
    wb       = !scan.hit && !scan.inv_found && row_r[vic].dirty;

    for (int w = 0; w < salwc_pkg::NUM_WAYS; w++) begin
      row_nxt[w] = row_r[w];
      if (row_r[w].rank > old_rank) begin
        row_nxt[w].rank = row_r[w].rank - 1'b1;
      end
    end
    row_nxt[vic].rank = salwc_pkg::WAY_W'(salwc_pkg::NUM_WAYS - 1);
    if (scan.hit) begin
      row_nxt[vic].dirty = row_r[vic].dirty || (cmd_r == salwc_pkg::CMD_WRITE);
    end else begin
      row_nxt[vic].valid = 1'b1;
      row_nxt[vic].dirty = (cmd_r == salwc_pkg::CMD_WRITE);
      row_nxt[vic].tag   = tag_r;
    end

    out_nxt.hit       = scan.hit;
    out_nxt.writeback = wb;
    out_nxt.way_used  = 2'(vic);
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mem_we) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---- checks ----
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "accepted while busy")
  `ASSERT_NEVER(a_hit_no_wb, clk, rst_n, out_valid_r && out_r.hit && out_r.writeback, "writeback on hit")
  `ASSERT_CLK(a_set_init, clk, rst_n, mem_we |=> set_init_r[$past(set_r)], "set not marked written")

endmodule

// ===== tb/tb_set_assoc_lru_writeback_cache_unit.sv =====
// Self-checking testbench for the LRU write-back cache tag store.
`timescale 1ns / 100ps

module tb;
  import salwc_pkg::*;

  // Predicts the tag store: one entry of hit, writeback and way per access.
  class lru_tag_scoreboard;
    bit             line_valid [NUM_SETS][NUM_WAYS];
    bit             line_dirty [NUM_SETS][NUM_WAYS];
    bit [TAG_W-1:0] line_tag   [NUM_SETS][NUM_WAYS];
    bit [WAY_W-1:0] line_rank  [NUM_SETS][NUM_WAYS];  // NUM_WAYS-1 = most recent
    out_t           pending_lookups[$];
    int             errors;

    function new();
      errors = 0;
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          line_valid[s][w] = 1'b0;
          line_dirty[s][w] = 1'b0;
          line_tag[s][w]   = '0;
          line_rank[s][w]  = WAY_W'(w);
        end
      end
    endfunction

    // Accepted access beat: update the model and queue what the block must answer.
    function void note_access(in_t acc);
      int             set_idx;
      int             way;
      bit             found;
      bit [TAG_W-1:0] acc_tag;
      bit [WAY_W-1:0] old_rank;
      out_t           res;
      set_idx = int'(acc.address[OFFSET_BITS +: IDX_W]);
      acc_tag = acc.address[ADDR_BITS-1 -: TAG_W];
      res     = '0;
      way     = 0;
      found   = 1'b0;
      // lowest matching valid way wins
      for (int w = 0; w < NUM_WAYS; w++)
        if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == acc_tag) begin
          found = 1'b1;
          way   = w;
        end
      if (found) begin
        res.hit = 1'b1;
        if (acc.command == CMD_WRITE) line_dirty[set_idx][way] = 1'b1;
      end else begin
        for (int w = 0; w < NUM_WAYS; w++)
          if (!found && !line_valid[set_idx][w]) begin
            found = 1'b1;
            way   = w;
          end
        if (!found) begin
          // set full: victim is rank 0
          way = 0;
          for (int w = 0; w < NUM_WAYS; w++)
            if (line_rank[set_idx][w] < line_rank[set_idx][way]) way = w;
          res.writeback = line_dirty[set_idx][way];
        end
        line_tag[set_idx][way]   = acc_tag;
        line_valid[set_idx][way] = 1'b1;
        line_dirty[set_idx][way] = (acc.command == CMD_WRITE);
      end
      // promote: ways above the touched one slide down, touched way goes on top
      old_rank = line_rank[set_idx][way];
      for (int w = 0; w < NUM_WAYS; w++)
        if (line_rank[set_idx][w] > old_rank)
          line_rank[set_idx][w] = line_rank[set_idx][w] - 1'b1;
      line_rank[set_idx][way] = WAY_W'(NUM_WAYS - 1);
      res.way_used = 2'(way);
      pending_lookups.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_lookups.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending, actual %p", $time, got);
        return;
      end
      want = pending_lookups.pop_front();
      if (got.hit !== want.hit) begin
        errors++;
        $display("%0t: hit mismatch, expected %b actual %b", $time, want.hit, got.hit);
      end
      if (got.writeback !== want.writeback) begin
        errors++;
        $display("%0t: writeback mismatch, expected %b actual %b",
                 $time, want.writeback, got.writeback);
      end
      if (got.way_used !== want.way_used) begin
        errors++;
        $display("%0t: way_used mismatch, expected %0d actual %0d",
                 $time, want.way_used, got.way_used);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  lru_tag_scoreboard sb;

  // Idle odds per cycle, in percent, for each side; long receiver stall counter.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles_left = 0;

  // Small tag pool (more tags than ways) so hits and evictions both happen often.
  bit [TAG_W-1:0] tag_pool [6] = '{18'h00000, 18'h3FFFF, 18'h15555, 18'h2AAAA,
                                   18'h00001, 18'h20000};
  bit [IDX_W-1:0] hot_sets [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

  set_assoc_lru_writeback_cache_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_t mk_access(bit [TAG_W-1:0] t, bit [IDX_W-1:0] s,
                                    bit [OFFSET_BITS-1:0] o, cmd_e_t c);
    in_t a;
    a.address = {t, s, o};
    a.command = c;
    return a;
  endfunction

  // Mostly hot sets and pooled tags; the rest spread over the whole address range.
  function automatic in_t rand_access();
    bit [TAG_W-1:0] t;
    bit [IDX_W-1:0] s;
    s = ($urandom_range(0, 99) < 80) ? hot_sets[$urandom_range(0, 3)]
                                     : IDX_W'($urandom_range(0, NUM_SETS - 1));
    t = ($urandom_range(0, 99) < 85) ? tag_pool[$urandom_range(0, 5)] : TAG_W'($urandom);
    return mk_access(t, s, OFFSET_BITS'($urandom), cmd_e_t'($urandom_range(0, 1)));
  endfunction

  // One access beat: random gap, then hold valid until the handshake.
  task automatic send_access(in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_access(item);
  endtask

  // Stop offering, wait for every pending result, then let the pipe settle.
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_lookups.size() != 0) @(posedge clk);
    repeat (NUM_WAYS + 8) @(posedge clk);
  endtask

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_cycles_left > 0) begin
        out_ready <= 1'b0;
        stall_cycles_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: set 0 (plus one all-ones access) walks through cold fills, hits, promotion and evictions.
    send_access(mk_access(18'h00000, 8'h00, 6'h00, CMD_READ));   // cold miss, way 0
    send_access(mk_access(18'h3FFFF, 8'hFF, 6'h3F, CMD_WRITE));  // all-ones address
    send_access(mk_access(18'h00000, 8'h00, 6'h3F, CMD_READ));   // read hit
    send_access(mk_access(18'h00000, 8'h00, 6'h15, CMD_WRITE));  // write hit -> dirty
    send_access(mk_access(18'h00001, 8'h00, 6'h00, CMD_READ));
    send_access(mk_access(18'h00002, 8'h00, 6'h00, CMD_WRITE));
    send_access(mk_access(18'h00003, 8'h00, 6'h00, CMD_READ));   // set 0 now full
    send_access(mk_access(18'h00001, 8'h00, 6'h08, CMD_READ));   // promote from middle
    send_access(mk_access(18'h00004, 8'h00, 6'h00, CMD_READ));   // read fill over dirty
    send_access(mk_access(18'h00005, 8'h00, 6'h00, CMD_WRITE));
    send_access(mk_access(18'h00006, 8'h00, 6'h00, CMD_READ));
    send_access(mk_access(18'h00004, 8'h00, 6'h00, CMD_WRITE));  // clean hit -> dirty
    send_access(mk_access(18'h00007, 8'h00, 6'h00, CMD_READ));
    send_access(mk_access(18'h00005, 8'h00, 6'h01, CMD_READ));
    // Set 255 with extreme tags, then force the dirty all-ones line out.
    send_access(mk_access(18'h3FFFF, 8'hFF, 6'h00, CMD_READ));
    send_access(mk_access(18'h2AAAA, 8'hFF, 6'h2A, CMD_WRITE));
    send_access(mk_access(18'h15555, 8'hFF, 6'h15, CMD_READ));
    send_access(mk_access(18'h00001, 8'hFF, 6'h3F, CMD_WRITE));
    send_access(mk_access(18'h00000, 8'hFF, 6'h00, CMD_READ));   // evicts dirty LRU
    send_access(mk_access(18'h3FFFF, 8'hFF, 6'h00, CMD_READ));   // gone, miss again
    send_access(mk_access(18'h2AAAA, 8'h55, 6'h2A, CMD_WRITE));
    send_access(mk_access(18'h15555, 8'hAA, 6'h15, CMD_READ));

    // Sender mostly busy, receiver mostly stalled.
    send_idle_pct = 10;
    recv_idle_pct = 88;
    repeat (380) send_access(rand_access());

    // Sender pauses until the block has drained.
    wait_for_idle();

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct = 88;
    recv_idle_pct = 10;
    repeat (380) send_access(rand_access());

    // Full rate, with one long receiver hold-off that backs up the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (40) send_access(rand_access());
    stall_cycles_left = 300;
    repeat (350) send_access(rand_access());

    wait_for_idle();
    if (sb.errors == 0)
      $display("[set_assoc_lru_writeback_cache_unit] OK");
    else
      $display("[set_assoc_lru_writeback_cache_unit] ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("[set_assoc_lru_writeback_cache_unit] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/salwc_pkg.sv
rtl/core/salwc_way_scan.sv
rtl/core/set_assoc_lru_writeback_cache_unit.sv
tb/tb_set_assoc_lru_writeback_cache_unit.sv
